// ===== src/ptas_pkg.sv =====
// ----------------------------------------------------------------------------
// ptas_pkg
// Shared types, constants and the arctangent table of the turning angle sum.
// ----------------------------------------------------------------------------
package ptas_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int QUEUE_DEPTH      = 2;

    // result widths
    localparam int ANGLE_W = 16;
    localparam int TOTAL_W = 32;

    // segment vectors are brought below 2^PRE_BITS before the products
    localparam int PRE_BITS = 30;
    localparam int OPND_W   = PRE_BITS + 1;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int DOT_W    = PROD_W + 1;
    localparam int MAG_W    = PROD_W;

    // cordic datapath, top set bit of the normalized magnitudes
    localparam int NORM_TOP = 60;
    localparam int ROT_W    = 64;
    localparam int Z_W      = 25;
    localparam int STEP_W   = 5;

    localparam logic [STEP_W-1:0] SHRINK_LAST = STEP_W'(4);
    localparam logic [STEP_W-1:0] MUL_LAST    = STEP_W'(5);
    localparam logic [STEP_W-1:0] NORM_LAST   = STEP_W'(5);

    localparam logic signed [Z_W-1:0] DEG90_FINE = Z_W'(5898240);
    localparam logic [ANGLE_W-1:0]    TURN_MAX   = ANGLE_W'(46080);

    typedef struct packed {
        logic rotate;
        logic last;
    } job_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHRINK,
        ST_MUL,
        ST_NORM,
        ST_ROT,
        ST_ROUND,
        ST_DONE
    } back_state_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_fine(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117304);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            5'd20:   v = Z_W'(4);
            5'd21:   v = Z_W'(2);
            5'd22:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/ptas_queue.sv =====
// ----------------------------------------------------------------------------
// ptas_queue
// Small register queue that decouples the point front end from the back end.
// ----------------------------------------------------------------------------
module ptas_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ptas_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rd_data
);

    // depth is a power of two so the pointers wrap on their own
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign ready   = (count_reg != CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not follow a push");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ready)
        else $error("queue pushed while full");
`endif

endmodule

// ===== src/ptas_front.sv =====
// ----------------------------------------------------------------------------
// ptas_front
// Takes point beats, keeps the two previous points and queues segment jobs.
// ----------------------------------------------------------------------------
module ptas_front #(
    parameter int COORD_BITS = ptas_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic                         s_end_of_path,
    output logic                         q_push,
    input  logic                         q_ready,
    output ptas_pkg::job_ctrl_t          q_ctrl,
    output logic signed [COORD_BITS:0]   q_ax,
    output logic signed [COORD_BITS:0]   q_ay,
    output logic signed [COORD_BITS:0]   q_bx,
    output logic signed [COORD_BITS:0]   q_by
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam logic [1:0] HELD_FULL = 2'd2;

    logic signed [COORD_BITS-1:0] older_x_reg;
    logic signed [COORD_BITS-1:0] older_y_reg;
    logic signed [COORD_BITS-1:0] newer_x_reg;
    logic signed [COORD_BITS-1:0] newer_y_reg;
    logic [1:0]                   points_held_reg;
    logic                         accept;
    logic                         window_full;

    assign s_ready     = q_ready;
    assign accept      = s_valid && q_ready;
    assign window_full = (points_held_reg == HELD_FULL);

    assign q_ax = DIFF_W'(newer_x_reg) - DIFF_W'(older_x_reg);
    assign q_ay = DIFF_W'(newer_y_reg) - DIFF_W'(older_y_reg);
    assign q_bx = DIFF_W'(s_point_x) - DIFF_W'(newer_x_reg);
    assign q_by = DIFF_W'(s_point_y) - DIFF_W'(newer_y_reg);

    // a zero-length segment skips the angle unit and counts as no turn
    assign q_ctrl.rotate = window_full && ((q_ax != '0) || (q_ay != '0))
                           && ((q_bx != '0) || (q_by != '0));
    assign q_ctrl.last   = s_end_of_path;
    assign q_push        = accept && (window_full || s_end_of_path);

    always_ff @(posedge aclk) begin
        if (accept) begin
            older_x_reg <= newer_x_reg;
            older_y_reg <= newer_y_reg;
            newer_x_reg <= s_point_x;
            newer_y_reg <= s_point_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_held_reg <= '0;
        end else if (accept) begin
            if (s_end_of_path) begin
                points_held_reg <= '0;
            end else if (!window_full) begin
                points_held_reg <= points_held_reg + 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_path_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_path) |=> (points_held_reg == '0))
        else $error("window not cleared after last point");
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (points_held_reg != 2'd3))
        else $error("point count out of range");
`endif

endmodule

// ===== src/ptas_back.sv =====
// ----------------------------------------------------------------------------
// ptas_back
// Turning angle by products and a cordic vectoring pass, running total, output.
// ----------------------------------------------------------------------------
module ptas_back #(
    parameter int COORD_BITS   = ptas_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = ptas_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  ptas_pkg::job_ctrl_t            q_ctrl,
    input  logic signed [COORD_BITS:0]     q_ax,
    input  logic signed [COORD_BITS:0]     q_ay,
    input  logic signed [COORD_BITS:0]     q_bx,
    input  logic signed [COORD_BITS:0]     q_by,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ptas_pkg::ANGLE_W-1:0]   m_turn_angle,
    output logic [ptas_pkg::TOTAL_W-1:0]   m_angle_total,
    output logic                           m_total_final
);

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PRE_BITS = ptas_pkg::PRE_BITS;
    localparam int OPND_W   = ptas_pkg::OPND_W;
    localparam int PROD_W   = ptas_pkg::PROD_W;
    localparam int DOT_W    = ptas_pkg::DOT_W;
    localparam int MAG_W    = ptas_pkg::MAG_W;
    localparam int ROT_W    = ptas_pkg::ROT_W;
    localparam int Z_W      = ptas_pkg::Z_W;
    localparam int STEP_W   = ptas_pkg::STEP_W;
    localparam int ANGLE_W  = ptas_pkg::ANGLE_W;
    localparam int TOTAL_W  = ptas_pkg::TOTAL_W;
    localparam int SCL_W    = Z_W - 8;
    localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

    ptas_pkg::back_state_t state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;

    logic [DIFF_W-1:0] ax_mag_reg, ay_mag_reg, bx_mag_reg, by_mag_reg;
    logic              ax_neg_reg, ay_neg_reg, bx_neg_reg, by_neg_reg;
    logic              last_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [DOT_W-1:0]  cr_reg;
    logic signed [ROT_W-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [ANGLE_W-1:0]       turn_reg;
    logic [TOTAL_W-1:0]       acc_reg;

    logic                     m_valid_reg;
    logic [ANGLE_W-1:0]       m_turn_angle_reg;
    logic [TOTAL_W-1:0]       m_angle_total_reg;
    logic                     m_total_final_reg;

    logic                     out_free;

    // shrink step: shift a vector right while its larger component is too wide
    logic [4:0]        shr_amt;
    logic [DIFF_W-1:0] a_or, b_or;
    logic              a_big, b_big;

    // signed 31-bit operands of the products
    logic [DIFF_W+PRE_BITS-1:0] ax_ext, ay_ext, bx_ext, by_ext;
    logic signed [OPND_W-1:0]   ax_op, ay_op, bx_op, by_op;
    logic signed [OPND_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod_full;

    logic signed [DOT_W-1:0] dot_abs, cr_abs;
    logic [MAG_W-1:0]        dot_mag, cr_mag;
    logic                    mag_zero;

    logic [5:0]              shl_amt;
    logic [ROT_W-1:0]        xy_or;
    logic                    has_room;

    logic signed [ROT_W-1:0] sx, sy;
    logic                    y_pos;
    logic signed [Z_W-1:0]   atan_step;

    logic signed [Z_W-1:0]   z_rnd;
    logic [SCL_W-1:0]        z_scaled;

    logic [TOTAL_W:0]        acc_sum;
    logic [TOTAL_W-1:0]      acc_next;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ptas_pkg::ST_IDLE) && q_valid;

    assign shr_amt = 5'd16 >> step_reg[2:0];
    assign a_or    = ax_mag_reg | ay_mag_reg;
    assign b_or    = bx_mag_reg | by_mag_reg;
    assign a_big   = (a_or >> (PRE_BITS - 1 + int'(shr_amt))) != '0;
    assign b_big   = (b_or >> (PRE_BITS - 1 + int'(shr_amt))) != '0;

    assign ax_ext = {{PRE_BITS{1'b0}}, ax_mag_reg};
    assign ay_ext = {{PRE_BITS{1'b0}}, ay_mag_reg};
    assign bx_ext = {{PRE_BITS{1'b0}}, bx_mag_reg};
    assign by_ext = {{PRE_BITS{1'b0}}, by_mag_reg};
    assign ax_op  = ax_neg_reg ? -$signed({1'b0, ax_ext[PRE_BITS-1:0]})
                               :  $signed({1'b0, ax_ext[PRE_BITS-1:0]});
    assign ay_op  = ay_neg_reg ? -$signed({1'b0, ay_ext[PRE_BITS-1:0]})
                               :  $signed({1'b0, ay_ext[PRE_BITS-1:0]});
    assign bx_op  = bx_neg_reg ? -$signed({1'b0, bx_ext[PRE_BITS-1:0]})
                               :  $signed({1'b0, bx_ext[PRE_BITS-1:0]});
    assign by_op  = by_neg_reg ? -$signed({1'b0, by_ext[PRE_BITS-1:0]})
                               :  $signed({1'b0, by_ext[PRE_BITS-1:0]});

    // one shared multiplier: ax*bx, ay*by, ax*by, ay*bx in turn
    always_comb begin
        unique case (step_reg[1:0])
            2'd0: begin
                mul_a = ax_op;
                mul_b = bx_op;
            end
            2'd1: begin
                mul_a = ay_op;
                mul_b = by_op;
            end
            2'd2: begin
                mul_a = ax_op;
                mul_b = by_op;
            end
            default: begin
                mul_a = ay_op;
                mul_b = bx_op;
            end
        endcase
    end

    assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign dot_abs  = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;
    assign cr_abs   = cr_reg[DOT_W-1] ? -cr_reg : cr_reg;
    assign dot_mag  = dot_abs[MAG_W-1:0];
    assign cr_mag   = cr_abs[MAG_W-1:0];
    assign mag_zero = (dot_mag | cr_mag) == '0;

    assign shl_amt  = 6'd32 >> step_reg[2:0];
    assign xy_or    = x_reg | y_reg;
    assign has_room = (xy_or >> (ptas_pkg::NORM_TOP + 1 - int'(shl_amt))) == '0;

    assign sx        = x_reg >>> step_reg;
    assign sy        = y_reg >>> step_reg;
    assign y_pos     = !y_reg[ROT_W-1] && (y_reg != '0);
    assign atan_step = ptas_pkg::atan_fine(step_reg);

    assign z_rnd    = z_reg + Z_W'(128);
    assign z_scaled = z_rnd[Z_W-1:8];

    assign acc_sum  = {1'b0, acc_reg} + (TOTAL_W + 1)'(turn_reg);
    assign acc_next = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptas_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_ctrl.rotate ? ptas_pkg::ST_SHRINK : ptas_pkg::ST_DONE;
                end
            end
            ptas_pkg::ST_SHRINK: begin
                if (step_reg == ptas_pkg::SHRINK_LAST) begin
                    state_next = ptas_pkg::ST_MUL;
                end
            end
            ptas_pkg::ST_MUL: begin
                if (step_reg == ptas_pkg::MUL_LAST) begin
                    state_next = mag_zero ? ptas_pkg::ST_DONE : ptas_pkg::ST_NORM;
                end
            end
            ptas_pkg::ST_NORM: begin
                if (step_reg == ptas_pkg::NORM_LAST) begin
                    state_next = ptas_pkg::ST_ROT;
                end
            end
            ptas_pkg::ST_ROT: begin
                if (step_reg == ROT_LAST) begin
                    state_next = ptas_pkg::ST_ROUND;
                end
            end
            ptas_pkg::ST_ROUND: begin
                state_next = ptas_pkg::ST_DONE;
            end
            ptas_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ptas_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptas_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptas_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + STEP_W'(1);
            if (state_reg == ptas_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                acc_reg     <= last_reg ? '0 : acc_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ptas_pkg::ST_IDLE: begin
                ax_mag_reg <= q_ax[DIFF_W-1] ? DIFF_W'(-q_ax) : DIFF_W'(q_ax);
                ay_mag_reg <= q_ay[DIFF_W-1] ? DIFF_W'(-q_ay) : DIFF_W'(q_ay);
                bx_mag_reg <= q_bx[DIFF_W-1] ? DIFF_W'(-q_bx) : DIFF_W'(q_bx);
                by_mag_reg <= q_by[DIFF_W-1] ? DIFF_W'(-q_by) : DIFF_W'(q_by);
                ax_neg_reg <= q_ax[DIFF_W-1];
                ay_neg_reg <= q_ay[DIFF_W-1];
                bx_neg_reg <= q_bx[DIFF_W-1];
                by_neg_reg <= q_by[DIFF_W-1];
                last_reg   <= q_ctrl.last;
                turn_reg   <= '0;
            end
            ptas_pkg::ST_SHRINK: begin
                if (a_big) begin
                    ax_mag_reg <= ax_mag_reg >> shr_amt;
                    ay_mag_reg <= ay_mag_reg >> shr_amt;
                end
                if (b_big) begin
                    bx_mag_reg <= bx_mag_reg >> shr_amt;
                    by_mag_reg <= by_mag_reg >> shr_amt;
                end
            end
            ptas_pkg::ST_MUL: begin
                prod_reg <= prod_full;
                unique case (step_reg[2:0])
                    3'd1:    dot_reg <= DOT_W'(prod_reg);
                    3'd2:    dot_reg <= dot_reg + DOT_W'(prod_reg);
                    3'd3:    cr_reg  <= DOT_W'(prod_reg);
                    3'd4:    cr_reg  <= cr_reg - DOT_W'(prod_reg);
                    default: begin
                    end
                endcase
                // seed the rotator in the quadrant picked by the sign of dot
                if (step_reg == ptas_pkg::MUL_LAST) begin
                    if (!dot_reg[DOT_W-1]) begin
                        x_reg <= $signed(ROT_W'(dot_mag));
                        y_reg <= $signed(ROT_W'(cr_mag));
                        z_reg <= '0;
                    end else begin
                        x_reg <= $signed(ROT_W'(cr_mag));
                        y_reg <= $signed(ROT_W'(dot_mag));
                        z_reg <= ptas_pkg::DEG90_FINE;
                    end
                end
            end
            ptas_pkg::ST_NORM: begin
                if (has_room) begin
                    x_reg <= x_reg <<< shl_amt;
                    y_reg <= y_reg <<< shl_amt;
                end
            end
            ptas_pkg::ST_ROT: begin
                if (y_pos) begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    z_reg <= z_reg + atan_step;
                end else begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    z_reg <= z_reg - atan_step;
                end
            end
            ptas_pkg::ST_ROUND: begin
                if (z_reg[Z_W-1]) begin
                    turn_reg <= '0;
                end else if (z_scaled > SCL_W'(ptas_pkg::TURN_MAX)) begin
                    turn_reg <= ptas_pkg::TURN_MAX;
                end else begin
                    turn_reg <= z_scaled[ANGLE_W-1:0];
                end
            end
            ptas_pkg::ST_DONE: begin
                if (out_free) begin
                    m_turn_angle_reg  <= turn_reg;
                    m_angle_total_reg <= acc_next;
                    m_total_final_reg <= last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_turn_angle  = m_turn_angle_reg;
    assign m_angle_total = m_angle_total_reg;
    assign m_total_final = m_total_final_reg;

`ifndef SYNTHESIS
    a_turn_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_turn_angle_reg <= ptas_pkg::TURN_MAX))
        else $error("turn angle above limit");
    a_rot_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptas_pkg::ST_ROT) |-> (step_reg <= ROT_LAST))
        else $error("cordic ran past its step count");
    a_total_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptas_pkg::ST_DONE && out_free && last_reg) |=> (acc_reg == '0))
        else $error("running total not cleared after final beat");
`endif

endmodule

// ===== src/polyline_turning_angle_sum_core.sv =====
// ----------------------------------------------------------------------------
// polyline_turning_angle_sum_core
// Turning points use the shared multiplier and the iterative cordic rotator; jobs
//   without a turn skip both. The back end works on one job at a time, and the
//   queue lets the front end keep accepting points until it is full.
// Reset: synchronous aresetn clears the window, the running total and the queue.
// ----------------------------------------------------------------------------
module polyline_turning_angle_sum_core #(
    parameter int COORD_BITS   = ptas_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = ptas_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic                         s_end_of_path,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ptas_pkg::ANGLE_W-1:0] m_turn_angle,
    output logic [ptas_pkg::TOTAL_W-1:0] m_angle_total,
    output logic                         m_total_final
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int CTRL_W = $bits(ptas_pkg::job_ctrl_t);
    localparam int Q_W    = CTRL_W + 4 * DIFF_W;

    logic                       q_push, q_ready, q_valid, q_pop;
    ptas_pkg::job_ctrl_t        wr_ctrl, rd_ctrl;
    logic signed [DIFF_W-1:0]   wr_ax, wr_ay, wr_bx, wr_by;
    logic signed [DIFF_W-1:0]   rd_ax, rd_ay, rd_bx, rd_by;
    logic [Q_W-1:0]             q_wr_data, q_rd_data;

    ptas_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_end_of_path(s_end_of_path),
        .q_push       (q_push),
        .q_ready      (q_ready),
        .q_ctrl       (wr_ctrl),
        .q_ax         (wr_ax),
        .q_ay         (wr_ay),
        .q_bx         (wr_bx),
        .q_by         (wr_by)
    );

    assign q_wr_data = {wr_ctrl, wr_ax, wr_ay, wr_bx, wr_by};

    ptas_queue #(
        .WIDTH(Q_W),
        .DEPTH(ptas_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wr_data(q_wr_data),
        .ready  (q_ready),
        .pop    (q_pop),
        .valid  (q_valid),
        .rd_data(q_rd_data)
    );

    assign rd_ctrl = ptas_pkg::job_ctrl_t'(q_rd_data[Q_W-1 -: CTRL_W]);
    assign rd_ax   = $signed(q_rd_data[4*DIFF_W-1 -: DIFF_W]);
    assign rd_ay   = $signed(q_rd_data[3*DIFF_W-1 -: DIFF_W]);
    assign rd_bx   = $signed(q_rd_data[2*DIFF_W-1 -: DIFF_W]);
    assign rd_by   = $signed(q_rd_data[DIFF_W-1:0]);

    ptas_back #(
        .COORD_BITS  (COORD_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ctrl       (rd_ctrl),
        .q_ax         (rd_ax),
        .q_ay         (rd_ay),
        .q_bx         (rd_bx),
        .q_by         (rd_by),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_turn_angle (m_turn_angle),
        .m_angle_total(m_angle_total),
        .m_total_final(m_total_final)
    );

endmodule
